[hdl/scd_pkg.sv]
// scd_pkg: shared types, scan code constants and key maps for the scan code decoder.
// No dependencies; used by scd_decode and scan_code_to_ascii_decoder_unit.
package scd_pkg;

    // state memory geometry: one live entry, address width of one bit
    localparam int ST_DEPTH = 2;
    localparam int ST_AW    = 1;
    localparam logic [ST_AW-1:0] ST_ENTRY = '0;

    localparam logic [7:0] CODE_CTRL   = 8'h1D;
    localparam logic [7:0] CODE_LSHIFT = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT = 8'h36;
    localparam logic [7:0] CODE_ALT    = 8'h38;
    localparam logic [7:0] CODE_CAPS   = 8'h3A;
    localparam logic [7:0] RELEASE_BIT = 8'h80;
    localparam logic [7:0] REL_CTRL    = CODE_CTRL | RELEASE_BIT;
    localparam logic [7:0] REL_LSHIFT  = CODE_LSHIFT | RELEASE_BIT;
    localparam logic [7:0] REL_RSHIFT  = CODE_RSHIFT | RELEASE_BIT;
    localparam logic [7:0] REL_ALT     = CODE_ALT | RELEASE_BIT;
    localparam logic [7:0] TABLE_LEN   = 8'h57;

    localparam logic [7:0] CHAR_ESC    = 8'h1B;
    localparam logic [7:0] CHAR_BS     = 8'h08;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_POUND  = 8'hA3;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic       shift;
        logic       control;
        logic       alt;
        logic       caps;
        logic [7:0] ch;
    } state_t;

    localparam int ST_W = $bits(state_t);

    localparam state_t STATE_RESET = '{shift: 1'b0, control: 1'b0, alt: 1'b0,
                                       caps: 1'b0, ch: 8'h00};

    function automatic logic [7:0] plain_char(input logic [6:0] code);
        logic [7:0] c;
        c = 8'h00;
        case (code)
            7'h01: c = CHAR_ESC;
            7'h02: c = "1";  7'h03: c = "2";  7'h04: c = "3";  7'h05: c = "4";
            7'h06: c = "5";  7'h07: c = "6";  7'h08: c = "7";  7'h09: c = "8";
            7'h0A: c = "9";  7'h0B: c = "0";  7'h0C: c = "-";  7'h0D: c = "=";
            7'h0E: c = CHAR_BS;  7'h0F: c = " ";
            7'h10: c = "q";  7'h11: c = "w";  7'h12: c = "e";  7'h13: c = "r";
            7'h14: c = "t";  7'h15: c = "y";  7'h16: c = "u";  7'h17: c = "i";
            7'h18: c = "o";  7'h19: c = "p";  7'h1A: c = "[";  7'h1B: c = "]";
            7'h1C: c = CHAR_LF;
            7'h1E: c = "a";  7'h1F: c = "s";  7'h20: c = "d";  7'h21: c = "f";
            7'h22: c = "g";  7'h23: c = "h";  7'h24: c = "j";  7'h25: c = "k";
            7'h26: c = "l";  7'h27: c = ";";  7'h28: c = 8'h27; 7'h2B: c = "#";
            7'h2C: c = "z";  7'h2D: c = "x";  7'h2E: c = "c";  7'h2F: c = "v";
            7'h30: c = "b";  7'h31: c = "n";  7'h32: c = "m";  7'h33: c = ",";
            7'h34: c = ".";  7'h35: c = "/";  7'h37: c = "*";  7'h39: c = " ";
            7'h47: c = "7";  7'h48: c = "8";  7'h49: c = "9";  7'h4A: c = "-";
            7'h4B: c = "4";  7'h4C: c = "5";  7'h4D: c = "6";  7'h4E: c = "+";
            7'h4F: c = "1";  7'h50: c = "2";  7'h51: c = "3";  7'h52: c = "0";
            7'h53: c = ".";  7'h56: c = 8'h5C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // shifted forms of digits and symbols, zero where there is none
    function automatic logic [7:0] shift_char(input logic [6:0] code);
        logic [7:0] c;
        c = 8'h00;
        case (code)
            7'h02: c = "!";  7'h03: c = 8'h22; 7'h04: c = CHAR_POUND;
            7'h05: c = "$";  7'h06: c = "%";  7'h07: c = "^";  7'h08: c = "&";
            7'h09: c = "*";  7'h0A: c = "(";  7'h0B: c = ")";  7'h0C: c = "_";
            7'h0D: c = "+";  7'h1A: c = "{";  7'h1B: c = "}";  7'h27: c = ":";
            7'h28: c = "|";  7'h2B: c = "~";  7'h33: c = "<";  7'h34: c = ">";
            7'h35: c = "?";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hdl/scd_ram.sv]
// scd_ram: generic simple dual port RAM, one write port, one registered read port.
// No dependencies.
module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read during write returns the old contents
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/scd_decode.sv]
// scd_decode: next state for one scan code, given the current flags and held character.
// Depends on scd_pkg.
module scd_decode (
    input  logic [7:0]          code,
    input  scd_pkg::state_t     cur,
    output scd_pkg::state_t     nxt
);

    logic [7:0] plain;
    logic [7:0] shifted;
    logic [7:0] key_char;
    logic       is_lower;

    always_comb
    begin
        plain    = scd_pkg::plain_char(code[6:0]);
        shifted  = scd_pkg::shift_char(code[6:0]);
        is_lower = (plain >= "a") && (plain <= "z");

        priority if (code >= scd_pkg::TABLE_LEN)
        begin
            key_char = 8'h00;
        end
        else if (is_lower)
        begin
            key_char = (cur.shift || cur.caps) ? plain - scd_pkg::CASE_OFFSET : plain;
        end
        else if (cur.shift && (shifted != 8'h00))
        begin
            key_char = shifted;
        end
        else
        begin
            key_char = plain;
        end
    end

    always_comb
    begin
        nxt = cur;
        priority if (code == scd_pkg::CODE_CTRL)
        begin
            nxt.control = 1'b1;
        end
        else if (code == scd_pkg::CODE_LSHIFT || code == scd_pkg::CODE_RSHIFT)
        begin
            nxt.shift = 1'b1;
        end
        else if (code == scd_pkg::CODE_ALT)
        begin
            nxt.alt = 1'b1;
        end
        else if (code == scd_pkg::CODE_CAPS)
        begin
            nxt.caps = !cur.caps;
        end
        else if (code == scd_pkg::REL_CTRL)
        begin
            nxt.control = 1'b0;
        end
        else if (code == scd_pkg::REL_LSHIFT || code == scd_pkg::REL_RSHIFT)
        begin
            nxt.shift = 1'b0;
        end
        else if (code == scd_pkg::REL_ALT)
        begin
            nxt.alt = 1'b0;
        end
        else
        begin
            nxt.ch = key_char;
        end
    end

endmodule

[hdl/scan_code_to_ascii_decoder_unit.sv]
// scan_code_to_ascii_decoder_unit: top level of the set 1 scan code decoder.
// Depends on scd_pkg, scd_ram and scd_decode.
//
// Input channel: in_valid / in_ready with one raw set 1 scan code byte per item.
// Output channel: out_valid / out_ready, one result item per input item: the
// held character plus the shift, control, alt and caps lock flags.
// Each accepted item waits in the read stage (code_reg, with its state read from
// the RAM); as it leaves, its state is updated, written back and loaded into the
// output register. Throughput: one item per cycle while the receiver keeps up; the
// read of the state memory and the write back overlap, and an item whose read
// crosses the write of the item ahead of it takes the forwarded state.
// The state lives in a small RAM; a valid flag cleared at reset makes the
// entry read as all flags clear and character 0 until the first write.
// When the receiver stalls, the result stays in the output register, the
// item behind it waits in the read stage and in_ready drops; nothing is lost.
module scan_code_to_ascii_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] scan_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] character,
    output logic       shift_down,
    output logic       control_down,
    output logic       alt_down,
    output logic       caps_active
);

    logic                         in_fire;
    logic                         s1_adv;
    logic                         v1_reg;
    logic [7:0]                   code_reg;
    logic                         out_valid_reg;
    scd_pkg::state_t              out_state_reg;
    logic                         st_valid_reg;
    logic                         fwd_sel_reg;
    scd_pkg::state_t              fwd_reg;
    logic [scd_pkg::ST_W-1:0]     rd_data;
    scd_pkg::state_t              cur_state;
    scd_pkg::state_t              nxt_state;

    assign s1_adv   = v1_reg && (!out_valid_reg || out_ready);
    assign in_ready = !v1_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    scd_ram #(
        .WIDTH (scd_pkg::ST_W),
        .DEPTH (scd_pkg::ST_DEPTH)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (scd_pkg::ST_ENTRY),
        .wr_data (nxt_state),
        .rd_en   (in_fire),
        .rd_addr (scd_pkg::ST_ENTRY),
        .rd_data (rd_data)
    );

    // the read missed a write landing at the same edge: take the forwarded copy
    always_comb
    begin
        priority if (fwd_sel_reg)
        begin
            cur_state = fwd_reg;
        end
        else if (st_valid_reg)
        begin
            cur_state = scd_pkg::state_t'(rd_data);
        end
        else
        begin
            cur_state = scd_pkg::STATE_RESET;
        end
    end

    scd_decode u_decode (
        .code (code_reg),
        .cur  (cur_state),
        .nxt  (nxt_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            st_valid_reg  <= 1'b0;
            fwd_sel_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                v1_reg      <= 1'b1;
                fwd_sel_reg <= s1_adv;
            end
            else if (s1_adv)
            begin
                v1_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                st_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            code_reg <= scan_code;
        end
        if (s1_adv)
        begin
            fwd_reg       <= nxt_state;
            out_state_reg <= nxt_state;
        end
    end

    assign out_valid    = out_valid_reg;
    assign character    = out_state_reg.ch;
    assign shift_down   = out_state_reg.shift;
    assign control_down = out_state_reg.control;
    assign alt_down     = out_state_reg.alt;
    assign caps_active  = out_state_reg.caps;

`ifndef SYNTHESIS
    // a stalled item keeps its code in the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !s1_adv |=> v1_reg && $stable(code_reg))
        else $error("read stage item lost while stalled");

    // a read overlapping a write back must select the forwarded state
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s1_adv |=> fwd_sel_reg)
        else $error("forwarding not selected after overlapping write");

    // no result can exist before the state entry has been written once
    assert property (@(posedge clk) disable iff (!rst_n)
        !st_valid_reg |-> !out_valid_reg && !fwd_sel_reg)
        else $error("result present without a written state entry");
`endif

endmodule

[sim/scan_code_to_ascii_decoder_unit_tb.sv]
// scan_code_to_ascii_decoder_unit_tb: self-checking bench for the set 1 scan code decoder.
// Depends on scd_pkg and scan_code_to_ascii_decoder_unit; keyboard state is predicted
// here from its own key tables, results are checked in order with random handshake stalls.
module scan_code_to_ascii_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_KEYS = 25;
    localparam int RANDOM_KEYS   = 1525;
    localparam int HOLD_AT       = 300;   // result count where the receiver stalls long
    localparam int HOLD_CYCLES   = 80;
    localparam int PAUSE_AT      = 900;   // random item where the sender drains the block

    typedef struct {
        logic [7:0]      code;
        bit              typed;   // result written out below instead of predicted
        scd_pkg::state_t want;    // {shift, control, alt, caps, character}
    } key_row_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] scan_code = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] character;
    logic       shift_down;
    logic       control_down;
    logic       alt_down;
    logic       caps_active;

    scd_pkg::state_t kbd_state = scd_pkg::STATE_RESET;
    scd_pkg::state_t expected_q[$];
    int     error_count = 0;
    int     results_seen = 0;

    key_row_t directed_keys [DIRECTED_KEYS] = '{
        '{8'h00, 1'b1, {4'b0000, 8'h00}},        // unmapped code straight after reset
        '{8'h1E, 1'b0, {4'b0000, 8'h00}},
        '{scd_pkg::CODE_LSHIFT, 1'b0, {4'b0000, 8'h00}},
        '{8'h1E, 1'b0, {4'b0000, 8'h00}},
        '{8'h04, 1'b1, {4'b1000, scd_pkg::CHAR_POUND}},   // pound sign with shift held
        '{scd_pkg::REL_LSHIFT, 1'b0, {4'b0000, 8'h00}},
        '{scd_pkg::CODE_CAPS, 1'b0, {4'b0000, 8'h00}},
        '{8'h10, 1'b0, {4'b0000, 8'h00}},
        '{8'h02, 1'b0, {4'b0000, 8'h00}},        // caps lock leaves digits alone
        '{scd_pkg::CODE_CAPS, 1'b0, {4'b0000, 8'h00}},
        '{scd_pkg::CODE_CTRL, 1'b0, {4'b0000, 8'h00}},
        '{scd_pkg::CODE_ALT, 1'b0, {4'b0000, 8'h00}},
        '{8'h0F, 1'b1, {4'b0110, 8'h20}},        // tab gives a space
        '{scd_pkg::REL_CTRL, 1'b0, {4'b0000, 8'h00}},
        '{scd_pkg::REL_ALT, 1'b0, {4'b0000, 8'h00}},
        '{scd_pkg::CODE_RSHIFT, 1'b0, {4'b0000, 8'h00}},
        '{8'h35, 1'b0, {4'b0000, 8'h00}},
        '{scd_pkg::REL_RSHIFT, 1'b0, {4'b0000, 8'h00}},
        '{8'h9E, 1'b1, {4'b0000, 8'h00}},        // release of a normal key
        '{8'h01, 1'b1, {4'b0000, scd_pkg::CHAR_ESC}},
        '{8'h56, 1'b0, {4'b0000, 8'h00}},
        '{scd_pkg::TABLE_LEN, 1'b1, {4'b0000, 8'h00}},    // first code past the key table
        '{8'hFF, 1'b1, {4'b0000, 8'h00}},
        '{8'h7F, 1'b1, {4'b0000, 8'h00}},
        '{8'h1C, 1'b0, {4'b0000, 8'h00}}
    };

    scan_code_to_ascii_decoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .scan_code   (scan_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .character   (character),
        .shift_down  (shift_down),
        .control_down(control_down),
        .alt_down    (alt_down),
        .caps_active (caps_active)
    );

    // uk layout lookup for a pressed key under the current modifiers
    function automatic logic [7:0] uk_key_char(scd_pkg::state_t s, logic [7:0] code);
        string      digit_row   = "1234567890-=";    // 0x02..0x0D
        string      digit_shift = "!\" $%^&*()_+";   // pound handled apart
        string      upper_row   = "qwertyuiop[]";    // 0x10..0x1B
        string      home_row    = "asdfghjkl;'";     // 0x1E..0x28
        string      lower_row   = "zxcvbnm,./";      // 0x2C..0x35
        string      keypad      = "789-456+1230.";   // 0x47..0x53
        logic [7:0] c;
        c = 8'h00;
        if (code >= 8'h02 && code <= 8'h0D)
            c = digit_row[code - 8'h02];
        else if (code >= 8'h10 && code <= 8'h1B)
            c = upper_row[code - 8'h10];
        else if (code >= 8'h1E && code <= 8'h28)
            c = home_row[code - 8'h1E];
        else if (code >= 8'h2C && code <= 8'h35)
            c = lower_row[code - 8'h2C];
        else if (code >= 8'h47 && code <= 8'h53)
            c = keypad[code - 8'h47];
        else
            case (code)
                8'h01:   c = scd_pkg::CHAR_ESC;
                8'h0E:   c = scd_pkg::CHAR_BS;
                8'h0F:   c = " ";
                8'h1C:   c = scd_pkg::CHAR_LF;
                8'h2B:   c = "#";
                8'h37:   c = "*";
                8'h39:   c = " ";
                8'h56:   c = "\\";
                default: c = 8'h00;
            endcase

        if (c >= "a" && c <= "z")
        begin
            if (s.shift || s.caps)
                c = c - scd_pkg::CASE_OFFSET;
        end
        else if (s.shift)
        begin
            if (code == 8'h04)
                c = scd_pkg::CHAR_POUND;
            else if (code >= 8'h02 && code <= 8'h0D)
                c = digit_shift[code - 8'h02];
            else
                case (code)
                    8'h1A: c = "{";
                    8'h1B: c = "}";
                    8'h27: c = ":";
                    8'h28: c = "|";
                    8'h2B: c = "~";
                    8'h33: c = "<";
                    8'h34: c = ">";
                    8'h35: c = "?";
                    default: ;
                endcase
        end
        return c;
    endfunction

    function automatic scd_pkg::state_t next_kbd_state(scd_pkg::state_t s, logic [7:0] code);
        scd_pkg::state_t n;
        n = s;
        case (code)
            scd_pkg::CODE_CTRL:                       n.control = 1'b1;
            scd_pkg::CODE_LSHIFT, scd_pkg::CODE_RSHIFT: n.shift = 1'b1;
            scd_pkg::CODE_ALT:                        n.alt = 1'b1;
            scd_pkg::CODE_CAPS:                       n.caps = ~s.caps;
            scd_pkg::REL_CTRL:                        n.control = 1'b0;
            scd_pkg::REL_LSHIFT, scd_pkg::REL_RSHIFT: n.shift = 1'b0;
            scd_pkg::REL_ALT:                         n.alt = 1'b0;
            default:                                  n.ch = uk_key_char(s, code);
        endcase
        return n;
    endfunction

    // mostly typing with modifiers around it, some key releases and raw noise
    function automatic logic [7:0] random_key_code();
        logic [7:0] modifiers [9] = '{scd_pkg::CODE_CTRL, scd_pkg::CODE_LSHIFT,
                                      scd_pkg::CODE_RSHIFT, scd_pkg::CODE_ALT,
                                      scd_pkg::CODE_CAPS, scd_pkg::REL_CTRL,
                                      scd_pkg::REL_LSHIFT, scd_pkg::REL_RSHIFT,
                                      scd_pkg::REL_ALT};
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return modifiers[$urandom_range(0, 8)];
        if (pick < 75)
            return 8'($urandom_range(0, scd_pkg::TABLE_LEN - 1));
        if (pick < 88)
            return scd_pkg::RELEASE_BIT | 8'($urandom_range(0, scd_pkg::TABLE_LEN - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 what, results_seen, got, want);
        error_count++;
    endtask

    // entered and left at a falling edge
    task automatic send_key(input logic [7:0] code, input bit typed,
                            input scd_pkg::state_t want, input int idx);
        int gap;
        gap = ((idx / 128) % 4 == 3) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        scan_code <= code;
        do @(posedge clk); while (!in_ready);
        kbd_state = next_kbd_state(kbd_state, code);
        expected_q.push_back(typed ? want : kbd_state);
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver
    initial
    begin
        int              gap;
        scd_pkg::state_t got;
        scd_pkg::state_t want;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (results_seen == HOLD_AT)
                gap = HOLD_CYCLES;
            else
                gap = ((results_seen / 96) % 4 == 1) ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = {shift_down, control_down, alt_down, caps_active, character};
            results_seen++;
            if (expected_q.size() == 0)
                note_mismatch("unexpected item", got.ch, 0);
            else
            begin
                want = expected_q.pop_front();
                if (got.ch !== want.ch)
                    note_mismatch("character", got.ch, want.ch);
                if (got.shift !== want.shift)
                    note_mismatch("shift_down", got.shift, want.shift);
                if (got.control !== want.control)
                    note_mismatch("control_down", got.control, want.control);
                if (got.alt !== want.alt)
                    note_mismatch("alt_down", got.alt, want.alt);
                if (got.caps !== want.caps)
                    note_mismatch("caps_active", got.caps, want.caps);
            end
            @(negedge clk);
        end
    end

    // sender and end of run
    initial
    begin
        int drain;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_KEYS; i++)
            send_key(directed_keys[i].code, directed_keys[i].typed, directed_keys[i].want, i);

        for (int i = 0; i < RANDOM_KEYS; i++)
        begin
            if (i == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (expected_q.size() != 0)
                    @(negedge clk);
            end
            send_key(random_key_code(), 1'b0, scd_pkg::STATE_RESET, DIRECTED_KEYS + i);
        end
        in_valid <= 1'b0;

        drain = 0;
        while (expected_q.size() != 0 && drain < 2000)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (8) @(negedge clk);
        if (expected_q.size() != 0)
            note_mismatch("missing items", expected_q.size(), 0);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
